// ----- hdl/jsu_pkg.sv -----
// ----------------------------------------------------------------------------
// jsu_pkg: shared types and constants for the JSON string unescaper
// Payload structs, decode modes, error codes and the UTF-8 run encoder.
// ----------------------------------------------------------------------------
package jsu_pkg;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_mark;
	} in_item_t;

	typedef enum logic [2:0] {
		ERR_NONE           = 3'd0,
		ERR_BAD_HEX        = 3'd1,
		ERR_MISSING_LOW    = 3'd2,
		ERR_BAD_LOW        = 3'd3,
		ERR_UNEXPECTED_LOW = 3'd4
	} err_code_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       run_last;
		logic       string_end;
		err_code_t  error_code;
	} out_item_t;

	// One input beat's worth of results: up to four bytes, or a single end/error result
	typedef struct packed {
		logic            has;
		logic            is_end;
		err_code_t       code;
		logic [1:0]      last;
		logic [3:0][7:0] bytes;
	} run_t;

	typedef enum logic [5:0] {
		M_PLAIN    = 6'b000001,
		M_ESC      = 6'b000010,
		M_HEX      = 6'b000100,
		M_HIGH     = 6'b001000,
		M_HIGH_BAD = 6'b010000,
		M_SKIP     = 6'b100000
	} mode_t;

	localparam logic [7:0]  CHAR_BACKSLASH = 8'h5C;
	localparam logic [7:0]  CHAR_U         = 8'h75;
	localparam logic [15:0] HIGH_FIRST     = 16'hD800;
	localparam logic [15:0] HIGH_LAST      = 16'hDBFF;
	localparam logic [15:0] LOW_FIRST      = 16'hDC00;
	localparam logic [15:0] LOW_LAST       = 16'hDFFF;
	localparam logic [20:0] SUPP_BASE      = 21'h10000;
	localparam logic [7:0]  UTF8_CONT      = 8'h80;
	localparam logic [7:0]  UTF8_LEAD2     = 8'hC0;
	localparam logic [7:0]  UTF8_LEAD3     = 8'hE0;
	localparam logic [7:0]  UTF8_LEAD4     = 8'hF0;

	// {ok, nibble}
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

	function automatic logic [7:0] simple_escape(input logic [7:0] c);
		logic [7:0] r;
		unique case (c)
			8'h62:   r = 8'h08;
			8'h66:   r = 8'h0C;
			8'h6E:   r = 8'h0A;
			8'h72:   r = 8'h0D;
			8'h74:   r = 8'h09;
			default: r = c;
		endcase
		return r;
	endfunction

	function automatic run_t byte_run(input logic [7:0] b);
		run_t r;
		r = '0;
		r.has = 1'b1;
		r.code = ERR_NONE;
		r.bytes[0] = b;
		return r;
	endfunction

	function automatic run_t end_run(input err_code_t code);
		run_t r;
		r = '0;
		r.has = 1'b1;
		r.is_end = 1'b1;
		r.code = code;
		return r;
	endfunction

	function automatic run_t utf8_run(input logic [20:0] cp);
		run_t r;
		r = '0;
		r.has = 1'b1;
		r.code = ERR_NONE;
		if (cp <= 21'h00007F) begin
			r.last = 2'd0;
			r.bytes[0] = cp[7:0];
		end else if (cp <= 21'h0007FF) begin
			r.last = 2'd1;
			r.bytes[0] = UTF8_LEAD2 | {3'b000, cp[10:6]};
			r.bytes[1] = UTF8_CONT | {2'b00, cp[5:0]};
		end else if (cp <= 21'h00FFFF) begin
			r.last = 2'd2;
			r.bytes[0] = UTF8_LEAD3 | {4'b0000, cp[15:12]};
			r.bytes[1] = UTF8_CONT | {2'b00, cp[11:6]};
			r.bytes[2] = UTF8_CONT | {2'b00, cp[5:0]};
		end else begin
			r.last = 2'd3;
			r.bytes[0] = UTF8_LEAD4 | {5'b00000, cp[20:18]};
			r.bytes[1] = UTF8_CONT | {2'b00, cp[17:12]};
			r.bytes[2] = UTF8_CONT | {2'b00, cp[11:6]};
			r.bytes[3] = UTF8_CONT | {2'b00, cp[5:0]};
		end
		return r;
	endfunction

endpackage

// ----- hdl/jsu_decode.sv -----
// ----------------------------------------------------------------------------
// jsu_decode: escape decoder
// Holds the decode state and turns one registered input beat into a run.
// ----------------------------------------------------------------------------
module jsu_decode (
	input  logic              clk,
	input  logic              arst_n,
	input  jsu_pkg::in_item_t item,
	input  logic              advance,
	output jsu_pkg::run_t     run
);

	jsu_pkg::mode_t mode_q, mode_d;
	logic [1:0]     count_q, count_d;
	logic [2:0]     bah_q, bah_d;
	logic [15:0]    acc_q, acc_d;
	logic [9:0]     high_q, high_d;

	logic [4:0]  hex;
	logic [15:0] acc_sh;
	logic [20:0] supp_cp;
	logic        low_bad;

	assign hex     = jsu_pkg::hex_digit(item.in_byte);
	assign acc_sh  = {acc_q[11:0], hex[3:0]};
	assign supp_cp = jsu_pkg::SUPP_BASE + {1'b0, high_q, acc_sh[9:0]};
	assign low_bad = (acc_sh < jsu_pkg::LOW_FIRST) || (acc_sh > jsu_pkg::LOW_LAST);

	always_comb begin
		mode_d  = mode_q;
		count_d = count_q;
		bah_d   = bah_q;
		acc_d   = acc_q;
		high_d  = high_q;
		run     = '0;
		if (item.end_mark) begin
			mode_d  = jsu_pkg::M_PLAIN;
			count_d = '0;
			bah_d   = '0;
			unique case (mode_q)
				jsu_pkg::M_SKIP:     run = '0;
				jsu_pkg::M_HEX:      run = jsu_pkg::end_run(jsu_pkg::ERR_BAD_HEX);
				jsu_pkg::M_HIGH,
				jsu_pkg::M_HIGH_BAD: run = jsu_pkg::end_run((bah_q >= 3'd5) ?
					jsu_pkg::ERR_BAD_HEX : jsu_pkg::ERR_MISSING_LOW);
				default:             run = jsu_pkg::end_run(jsu_pkg::ERR_NONE);
			endcase
		end else begin
			unique case (mode_q)
				jsu_pkg::M_ESC: begin
					if (item.in_byte == jsu_pkg::CHAR_U) begin
						mode_d  = jsu_pkg::M_HEX;
						count_d = '0;
						acc_d   = '0;
					end else begin
						mode_d = jsu_pkg::M_PLAIN;
						run    = jsu_pkg::byte_run(jsu_pkg::simple_escape(item.in_byte));
					end
				end
				jsu_pkg::M_HEX: begin
					if (!hex[4]) begin
						mode_d = jsu_pkg::M_SKIP;
						run    = jsu_pkg::end_run(jsu_pkg::ERR_BAD_HEX);
					end else begin
						acc_d   = acc_sh;
						count_d = count_q + 2'd1;
						if (count_q == 2'd3) begin
							count_d = '0;
							bah_d   = '0;
							if (acc_sh >= jsu_pkg::HIGH_FIRST && acc_sh <= jsu_pkg::HIGH_LAST) begin
								high_d = acc_sh[9:0];
								mode_d = jsu_pkg::M_HIGH;
							end else if (!low_bad) begin
								mode_d = jsu_pkg::M_SKIP;
								run    = jsu_pkg::end_run(jsu_pkg::ERR_UNEXPECTED_LOW);
							end else begin
								mode_d = jsu_pkg::M_PLAIN;
								run    = jsu_pkg::utf8_run({5'd0, acc_sh});
							end
						end
					end
				end
				jsu_pkg::M_HIGH,
				jsu_pkg::M_HIGH_BAD: begin
					if (bah_q == 3'd0) begin
						if (item.in_byte != jsu_pkg::CHAR_BACKSLASH) begin
							mode_d = jsu_pkg::M_SKIP;
							run    = jsu_pkg::end_run(jsu_pkg::ERR_MISSING_LOW);
						end else begin
							bah_d = 3'd1;
						end
					end else if (bah_q == 3'd1) begin
						if (item.in_byte != jsu_pkg::CHAR_U) begin
							mode_d = jsu_pkg::M_SKIP;
							run    = jsu_pkg::end_run(jsu_pkg::ERR_MISSING_LOW);
						end else begin
							bah_d = 3'd2;
							acc_d = '0;
						end
					end else begin
						// a bad low digit is only reported once all four have arrived
						if (hex[4]) begin
							acc_d = acc_sh;
						end else begin
							mode_d = jsu_pkg::M_HIGH_BAD;
						end
						bah_d = bah_q + 3'd1;
						if (bah_q == 3'd5) begin
							bah_d  = '0;
							mode_d = jsu_pkg::M_SKIP;
							if (mode_q == jsu_pkg::M_HIGH_BAD || !hex[4]) begin
								run = jsu_pkg::end_run(jsu_pkg::ERR_BAD_HEX);
							end else if (low_bad) begin
								run = jsu_pkg::end_run(jsu_pkg::ERR_BAD_LOW);
							end else begin
								mode_d = jsu_pkg::M_PLAIN;
								run    = jsu_pkg::utf8_run(supp_cp);
							end
						end
					end
				end
				jsu_pkg::M_SKIP: begin
					run = '0;
				end
				default: begin
					mode_d = jsu_pkg::M_PLAIN;
					if (item.in_byte == jsu_pkg::CHAR_BACKSLASH) begin
						mode_d = jsu_pkg::M_ESC;
					end else begin
						run = jsu_pkg::byte_run(item.in_byte);
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= jsu_pkg::M_PLAIN;
			count_q <= '0;
			bah_q   <= '0;
		end else if (advance) begin
			mode_q  <= mode_d;
			count_q <= count_d;
			bah_q   <= bah_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			acc_q  <= acc_d;
			high_q <= high_d;
		end
	end

	a_skip_silent: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == jsu_pkg::M_SKIP |-> !run.has)
		else $error("result produced while skipping a faulty string");

	a_bah_range: assert property (@(posedge clk) disable iff (!arst_n)
		bah_q <= 3'd5)
		else $error("low surrogate byte count out of range");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item.end_mark |=> mode_q == jsu_pkg::M_PLAIN && bah_q == 3'd0)
		else $error("end marker did not return decoder to plain text");

endmodule

// ----- hdl/jsu_emit.sv -----
// ----------------------------------------------------------------------------
// jsu_emit: result run register
// Holds one decoded run and hands it out one result per beat.
// ----------------------------------------------------------------------------
module jsu_emit (
	input  logic               clk,
	input  logic               arst_n,
	input  jsu_pkg::run_t      run,
	input  logic               load,
	output logic               free,
	output logic               out_valid,
	input  logic               out_ready,
	output jsu_pkg::out_item_t out_data
);

	logic          valid_s2;
	jsu_pkg::run_t run_s2;
	logic [1:0]    idx_q;
	logic          at_last;

	assign at_last   = (idx_q == run_s2.last);
	assign free      = !valid_s2 || (out_ready && at_last);
	assign out_valid = valid_s2;

	always_comb begin
		out_data            = '0;
		out_data.byte_valid = !run_s2.is_end;
		out_data.out_byte   = run_s2.is_end ? 8'h00 : run_s2.bytes[idx_q];
		out_data.run_last   = at_last;
		out_data.string_end = run_s2.is_end;
		out_data.error_code = run_s2.code;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= '0;
		end else if (load) begin
			valid_s2 <= 1'b1;
			idx_q    <= '0;
		end else if (valid_s2 && out_ready) begin
			// advance within the run, drop it after its last beat
			if (at_last) begin
				valid_s2 <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			run_s2 <= run;
		end
	end

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free)
		else $error("run loaded over one still being sent");

	a_idx_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> idx_q <= run_s2.last)
		else $error("beat index past end of run");

	a_end_single: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && run_s2.is_end |-> idx_q == 2'd0 && at_last)
		else $error("end or error result not a single-beat run");

endmodule

// ----- hdl/json_string_unescape_utf8.sv -----
// ----------------------------------------------------------------------------
// json_string_unescape_utf8: JSON string unescaper with UTF-8 output
// Decodes escapes and \u sequences (with surrogate pairs) of one string.
// ----------------------------------------------------------------------------
//  channel | dir | payload                 | handshake
//  --------+-----+-------------------------+-----------------------
//  in      | in  | jsu_pkg::in_item_t      | in_valid / in_ready
//  out     | out | jsu_pkg::out_item_t     | out_valid / out_ready
//
// One input beat per cycle unless the input side is held; a beat yielding results
// (up to four) waits in the input register until the single result run register is free.
// An accepted beat passes the input register, then the result run register, before its first result.
// Beats that yield no result pass through the input register without waiting
// on the output side. Reset empties both registers and returns to plain text.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8 (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  jsu_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output jsu_pkg::out_item_t out_data
);

	logic              valid_s1;
	jsu_pkg::in_item_t item_s1;
	jsu_pkg::run_t     run;
	logic              free;
	logic              advance;

	assign advance  = valid_s1 && (!run.has || free);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	jsu_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_s1),
		.advance (advance),
		.run     (run)
	);

	jsu_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.run       (run),
		.load      (advance && run.has),
		.free      (free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
